### rtl/core/fba_pkg.sv
// Package for the frame bitmap allocator: sizes, command codes, sequencer
// states, the bitmap access struct and the lowest-zero search function.
// Used by every file of the block; depends on nothing else.
`default_nettype none

package fba_pkg;

    localparam int NUM_FRAMES = 4096;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int MAP_WORDS  = NUM_FRAMES / WORD_W;
    localparam int ADDR_W     = $clog2(MAP_WORDS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int IDX_W      = 12;
    localparam int FC_W       = 13;
    localparam int DATA_W     = 16;

    localparam logic [WORD_W-1:0] FULL_WORD  = {WORD_W{1'b1}};
    localparam logic [FC_W-1:0]   FC_RESET   = FC_W'(4096);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_NOFREE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_map_req;

    // Position of the lowest clear bit; a full word gives the top position.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] b;
        b = BIT_W'(WORD_W - 1);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/core/fba_map.sv
// Bitmap store: one word per 32 frames, single read and write port,
// registered read data. Depends on fba_pkg.
`default_nettype none

module fba_map (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fba_pkg::t_map_req             i_req,
    output logic [fba_pkg::WORD_W-1:0]         o_rd_data
);

    logic [fba_pkg::WORD_W-1:0]    r_mem [fba_pkg::MAP_WORDS];
    logic [fba_pkg::MAP_WORDS-1:0] r_valid;
    logic [fba_pkg::WORD_W-1:0]    r_q;
    logic                          r_q_valid;

    // A word never written since reset reads as all frames free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_q       <= r_mem[i_req.rd_addr];
            r_q_valid <= r_valid[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_q_valid ? r_q : '0;

endmodule

`default_nettype wire

### rtl/core/fba_seq.sv
// Sequencer of the allocator: word-by-word first-fit scan, read-modify-write
// for free, and the result register. Depends on fba_pkg.
`default_nettype none

module fba_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [fba_pkg::FC_W-1:0]      i_frame_count,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_cmd,
    input  wire logic [fba_pkg::IDX_W-1:0]     i_frame_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [fba_pkg::IDX_W-1:0]          o_alloc_index,
    output logic                               o_status,
    output fba_pkg::t_map_req                  o_req,
    input  wire logic [fba_pkg::WORD_W-1:0]    i_rd_data
);

    fba_pkg::t_state                 r_state, n_state;
    logic [fba_pkg::CNT_W-1:0]       r_rd_word, n_rd_word;
    logic [fba_pkg::CNT_W-1:0]       r_lim, n_lim;
    logic [fba_pkg::ADDR_W-1:0]      r_chk_word, n_chk_word;
    logic                            r_chk_vld, n_chk_vld;
    logic [fba_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [fba_pkg::IDX_W-1:0]       r_res_index, n_res_index;
    logic                            r_res_status, n_res_status;
    logic                            r_out_valid, n_out_valid;
    logic [fba_pkg::IDX_W-1:0]       r_out_index, n_out_index;
    logic                            r_out_status, n_out_status;

    logic                            accept;
    logic                            found;
    logic                            issue;
    logic [fba_pkg::BIT_W-1:0]       zero_bit;
    logic [fba_pkg::CNT_W-1:0]       lim_now;
    logic                            out_free;
    logic                            idx_stored;
    logic [fba_pkg::ADDR_W-1:0]      idx_word;
    logic [fba_pkg::WORD_W-1:0]      idx_mask;

    assign accept     = i_in_valid && o_in_ready;
    assign found      = r_chk_vld && (i_rd_data != fba_pkg::FULL_WORD);
    assign issue      = r_rd_word < r_lim;
    assign zero_bit   = fba_pkg::lowest_zero(i_rd_data);
    assign out_free   = !r_out_valid || i_out_ready;
    assign idx_stored = 32'(r_idx) < 32'(fba_pkg::NUM_FRAMES);
    assign idx_word   = fba_pkg::ADDR_W'(r_idx >> fba_pkg::BIT_W);
    assign idx_mask   = ~(fba_pkg::WORD_W'(1) << r_idx[fba_pkg::BIT_W-1:0]);

    // Number of whole words to scan, clipped to the stored words.
    always_comb begin
        if (32'(i_frame_count >> fba_pkg::BIT_W) > 32'(fba_pkg::MAP_WORDS)) begin
            lim_now = fba_pkg::CNT_W'(fba_pkg::MAP_WORDS);
        end else begin
            lim_now = fba_pkg::CNT_W'(i_frame_count >> fba_pkg::BIT_W);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fba_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == fba_pkg::CMD_FREE) begin
                        n_state = fba_pkg::ST_FREE_RD;
                    end else if (lim_now == '0) begin
                        n_state = fba_pkg::ST_FIN;
                    end else begin
                        n_state = fba_pkg::ST_SCAN;
                    end
                end
            end
            fba_pkg::ST_SCAN: begin
                if (found || (!issue && !r_chk_vld)) begin
                    n_state = fba_pkg::ST_FIN;
                end
            end
            fba_pkg::ST_FREE_RD: n_state = fba_pkg::ST_FREE_WR;
            fba_pkg::ST_FREE_WR: n_state = fba_pkg::ST_FIN;
            fba_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = fba_pkg::ST_IDLE;
                end
            end
            default: n_state = fba_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_req         = '0;
        o_req.wr_data = i_rd_data | (fba_pkg::WORD_W'(1) << zero_bit);
        o_req.wr_addr = r_chk_word;
        o_req.rd_addr = fba_pkg::ADDR_W'(r_rd_word);
        case (r_state)
            fba_pkg::ST_SCAN: begin
                o_req.rd_en = issue && !found;
                o_req.wr_en = found;
            end
            fba_pkg::ST_FREE_RD: begin
                o_req.rd_en   = idx_stored;
                o_req.rd_addr = idx_word;
            end
            fba_pkg::ST_FREE_WR: begin
                o_req.wr_en   = idx_stored;
                o_req.wr_addr = idx_word;
                o_req.wr_data = i_rd_data & idx_mask;
            end
            default: o_req.rd_en = 1'b0;
        endcase
    end

    always_comb begin
        n_rd_word    = r_rd_word;
        n_lim        = r_lim;
        n_chk_word   = r_chk_word;
        n_chk_vld    = r_chk_vld;
        n_idx        = r_idx;
        n_res_index  = r_res_index;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_index  = r_out_index;
        n_out_status = r_out_status;
        case (r_state)
            fba_pkg::ST_IDLE: begin
                if (accept) begin
                    n_idx        = i_frame_index;
                    n_lim        = lim_now;
                    n_rd_word    = '0;
                    n_chk_vld    = 1'b0;
                    n_res_index  = '0;
                    n_res_status = ((i_cmd == fba_pkg::CMD_ALLOC) && (lim_now == '0))
                                   ? fba_pkg::STAT_NOFREE : fba_pkg::STAT_OK;
                end
            end
            fba_pkg::ST_SCAN: begin
                if (found) begin
                    n_res_index  = fba_pkg::IDX_W'({r_chk_word, zero_bit});
                    n_res_status = fba_pkg::STAT_OK;
                    n_chk_vld    = 1'b0;
                end else if (issue) begin
                    n_chk_word = fba_pkg::ADDR_W'(r_rd_word);
                    n_chk_vld  = 1'b1;
                    n_rd_word  = r_rd_word + 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                    if (!r_chk_vld) begin
                        n_res_status = fba_pkg::STAT_NOFREE;
                    end
                end
            end
            fba_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = r_res_index;
                    n_out_status = r_res_status;
                end
            end
            default: n_chk_vld = r_chk_vld;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fba_pkg::ST_IDLE;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_word    <= n_rd_word;
        r_lim        <= n_lim;
        r_chk_word   <= n_chk_word;
        r_idx        <= n_idx;
        r_res_index  <= n_res_index;
        r_res_status <= n_res_status;
        r_out_index  <= n_out_index;
        r_out_status <= n_out_status;
    end

    assign o_in_ready    = (r_state == fba_pkg::ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_alloc_index = r_out_index;
    assign o_status      = r_out_status;

endmodule

`default_nettype wire

### rtl/core/frame_bitmap_allocator_top.sv
// Top level of the first-fit frame bitmap allocator: stream ports, the
// frame count register, the sequencer and the bitmap store.
// Depends on fba_pkg, fba_seq and fba_map.
//
// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: cmd; tdata: frame_index
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser: status; tdata: alloc_index
// cfg       in         i_cfg_we                      i_cfg_wdata: frame_count
//
// One transaction is worked on at a time; the input is not ready meanwhile.
// A free reads the word, then writes it back, then loads the result register.
// An allocate scans from word 0 until a word holds a clear bit; one that finds
// no free frame scans all whole words (at most 128), or none if the frame count
// is below 32: the single bitmap read port moves one word per cycle. The last
// step waits while an earlier result is still held on the output, and the input
// is ready again in the same cycle the result register loads. Reset marks every
// frame free at once through per-word valid bits, so no clearing pass follows it.
`default_nettype none

module frame_bitmap_allocator_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fba_pkg::FC_W-1:0]      i_cfg_wdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [fba_pkg::DATA_W-1:0]    s_axis_tdata,  // [11:0] frame_index, rest zero
    input  wire logic                          s_axis_tuser,  // [0] cmd
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [fba_pkg::DATA_W-1:0]         m_axis_tdata,  // [11:0] alloc_index, rest zero
    output logic                               m_axis_tuser   // [0] status
);

    logic [fba_pkg::FC_W-1:0]   r_frame_count;
    fba_pkg::t_map_req          map_req;
    logic [fba_pkg::WORD_W-1:0] map_rd_data;
    logic [fba_pkg::IDX_W-1:0]  alloc_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= fba_pkg::FC_RESET;
        end else if (i_cfg_we) begin
            r_frame_count <= i_cfg_wdata;
        end
    end

    fba_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_count (r_frame_count),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_frame_index (s_axis_tdata[fba_pkg::IDX_W-1:0]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_alloc_index (alloc_index),
        .o_status      (m_axis_tuser),
        .o_req         (map_req),
        .i_rd_data     (map_rd_data)
    );

    fba_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (map_rd_data)
    );

    assign m_axis_tdata = fba_pkg::DATA_W'(alloc_index);

endmodule

`default_nettype wire

### rtl/core/fba_chk.sv
// Port-level checker for the frame bitmap allocator, bound to the top level.
// Depends on fba_pkg and frame_bitmap_allocator_top.
`default_nettype none

module fba_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [fba_pkg::DATA_W-1:0] m_axis_tdata,
    input wire logic                       m_axis_tuser
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Only one transaction is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready again the cycle after acceptance");

    // A failed allocate carries a zero index.
    a_nofree_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == fba_pkg::STAT_NOFREE)) |-> (m_axis_tdata == '0))
        else $error("nonzero index with no-free status");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind frame_bitmap_allocator_top fba_chk u_fba_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
